// File: rtl/core/pvrc_pkg.sv
// Package for the peak and valley run counter.
// Holds the register map, configuration reset values and the shared beat control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pvrc_pkg;

    localparam int CFG_WIDTH   = 16;
    localparam int PADDR_WIDTH = 3;
    localparam int PDATA_WIDTH = 32;

    localparam logic REG_PEAK_MIN_RUN   = 1'b0;
    localparam logic REG_VALLEY_MIN_RUN = 1'b1;

    localparam logic [CFG_WIDTH-1:0] PEAK_MIN_RUN_RESET   = 16'd2;
    localparam logic [CFG_WIDTH-1:0] VALLEY_MIN_RUN_RESET = 16'd2;

    typedef struct packed {
        logic valid;
        logic last;
    } t_beat_ctl;

endpackage

`default_nettype wire

// File: rtl/core/pvrc_in_stage.sv
// Input register stage of the peak and valley run counter.
// Captures one sample beat and holds it until the tracker consumes it; uses pvrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvrc_in_stage #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_last_sample,
    input  logic                           i_advance,
    output pvrc_pkg::t_beat_ctl            o_ctl,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample
);

    logic                           r_valid;
    logic                           r_last;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                           n_valid;
    logic                           w_accept;

    assign o_in_stall = r_valid && !i_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_sample;
            r_last   <= i_last_sample;
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_ctl.last  = r_last;
    assign o_sample    = r_sample;

endmodule

`default_nettype wire

// File: rtl/core/pvrc_tracker.sv
// Run tracker of the peak and valley run counter.
// Holds the direction, run lengths and counts and computes the stream result; uses pvrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvrc_tracker #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int RUN_WIDTH    = 16,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pvrc_pkg::t_beat_ctl                 i_step,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample,
    input  logic [pvrc_pkg::CFG_WIDTH-1:0]      i_peak_min_run,
    input  logic [pvrc_pkg::CFG_WIDTH-1:0]      i_valley_min_run,
    output logic [COUNT_WIDTH-1:0]              o_peak_count,
    output logic [COUNT_WIDTH-1:0]              o_valley_count
);

    localparam int CMP_WIDTH = (RUN_WIDTH > pvrc_pkg::CFG_WIDTH) ? RUN_WIDTH
                                                                 : pvrc_pkg::CFG_WIDTH;
    localparam logic [RUN_WIDTH-1:0] RUN_START = RUN_WIDTH'(2);

    logic [1:0]                     r_seen;
    logic signed [SAMPLE_WIDTH-1:0] r_prev;
    logic                           r_rising;
    logic [RUN_WIDTH-1:0]           r_run;
    logic [RUN_WIDTH-1:0]           r_prior;
    logic [COUNT_WIDTH-1:0]         r_peaks;
    logic [COUNT_WIDTH-1:0]         r_valleys;

    logic [1:0]                     n_seen;
    logic                           n_rising;
    logic [RUN_WIDTH-1:0]           n_run;
    logic [RUN_WIDTH-1:0]           n_prior;
    logic [COUNT_WIDTH-1:0]         n_peaks;
    logic [COUNT_WIDTH-1:0]         n_valleys;

    logic                           w_up;
    logic                           w_down;
    logic                           w_turn;
    logic                           w_peak_turn;
    logic                           w_valley_turn;
    logic                           w_peak_end;
    logic                           w_valley_end;
    logic [CMP_WIDTH-1:0]           w_run_x;
    logic [CMP_WIDTH-1:0]           w_prior_x;
    logic [CMP_WIDTH-1:0]           w_n_run_x;
    logic [CMP_WIDTH-1:0]           w_n_prior_x;
    logic [CMP_WIDTH-1:0]           w_pmin_x;
    logic [CMP_WIDTH-1:0]           w_vmin_x;
    logic [COUNT_WIDTH-1:0]         w_peaks_mid;
    logic [COUNT_WIDTH-1:0]         w_valleys_mid;

    assign w_up    = r_prev <= i_sample;
    assign w_down  = r_prev >= i_sample;
    assign w_turn  = r_rising ? !w_up : !w_down;

    assign w_run_x     = CMP_WIDTH'(r_run);
    assign w_prior_x   = CMP_WIDTH'(r_prior);
    assign w_n_run_x   = CMP_WIDTH'(n_run);
    assign w_n_prior_x = CMP_WIDTH'(n_prior);
    assign w_pmin_x    = CMP_WIDTH'(i_peak_min_run);
    assign w_vmin_x    = CMP_WIDTH'(i_valley_min_run);

    always_comb begin
        n_seen   = r_seen;
        n_rising = r_rising;
        n_run    = r_run;
        n_prior  = r_prior;
        unique case (r_seen)
            2'd0: begin
                n_seen = 2'd1;
            end
            2'd1: begin
                n_rising = i_sample >= r_prev;
                n_run    = RUN_START;
                n_prior  = '0;
                n_seen   = 2'd2;
            end
            default: begin
                n_seen = 2'd3;
                if (w_turn) begin
                    n_rising = !r_rising;
                    n_prior  = r_run;
                    n_run    = RUN_START;
                end else if (r_run != '1) begin
                    n_run = r_run + 1'b1;
                end
            end
        endcase
    end

    assign w_peak_turn   = r_seen[1] && w_turn && !r_rising
                           && (w_run_x >= w_pmin_x) && (w_prior_x >= w_pmin_x);
    assign w_valley_turn = r_seen[1] && w_turn && r_rising
                           && (w_run_x >= w_vmin_x) && (w_prior_x >= w_vmin_x);
    assign w_peak_end    = !n_rising && (w_n_run_x >= w_pmin_x) && (w_n_prior_x >= w_pmin_x);
    assign w_valley_end  = n_rising && (w_n_run_x >= w_vmin_x) && (w_n_prior_x >= w_vmin_x);

    always_comb begin
        n_peaks   = r_peaks;
        n_valleys = r_valleys;
        if (w_peak_turn && (r_peaks != '1)) begin
            n_peaks = r_peaks + 1'b1;
        end
        if (w_valley_turn && (r_valleys != '1)) begin
            n_valleys = r_valleys + 1'b1;
        end
    end

    always_comb begin
        w_peaks_mid   = n_peaks;
        w_valleys_mid = n_valleys;
        if (w_peak_end && (n_peaks != '1)) begin
            w_peaks_mid = n_peaks + 1'b1;
        end
        if (w_valley_end && (n_valleys != '1)) begin
            w_valleys_mid = n_valleys + 1'b1;
        end
        if (n_seen != 2'd3) begin
            o_peak_count   = '0;
            o_valley_count = '0;
        end else begin
            o_peak_count   = w_peaks_mid;
            o_valley_count = w_valleys_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.valid && i_step.last)) begin
            r_seen    <= 2'd0;
            r_prev    <= '0;
            r_rising  <= 1'b1;
            r_run     <= '0;
            r_prior   <= '0;
            r_peaks   <= '0;
            r_valleys <= '0;
        end else if (i_step.valid) begin
            r_seen    <= n_seen;
            r_prev    <= i_sample;
            r_rising  <= n_rising;
            r_run     <= n_run;
            r_prior   <= n_prior;
            r_peaks   <= n_peaks;
            r_valleys <= n_valleys;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/peak_valley_run_counter.sv
// A sample beat is first captured in the input register, and a last beat's result is then
// registered in the output register. Throughput: one sample beat per cycle while no last
// beat is held back; the tracker updates its run state once per beat.
// A last beat waits in the input register only while a previous result is still stalled.
// Reset is synchronous and active low; it clears the stream state and loads both minimum run
// registers with 2. Top level; depends on pvrc_pkg, pvrc_in_stage and pvrc_tracker.
`timescale 1ns / 1ps
`default_nettype none

module peak_valley_run_counter #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int RUN_WIDTH    = 16,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_sample,
    input  logic                                 i_last_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [COUNT_WIDTH-1:0]               o_peak_count,
    output logic [COUNT_WIDTH-1:0]               o_valley_count,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pvrc_pkg::PADDR_WIDTH-1:0]     paddr,
    input  logic [pvrc_pkg::PDATA_WIDTH-1:0]     pwdata,
    output logic [pvrc_pkg::PDATA_WIDTH-1:0]     prdata,
    output logic                                 pready
);

    logic [pvrc_pkg::CFG_WIDTH-1:0] r_peak_min_run;
    logic [pvrc_pkg::CFG_WIDTH-1:0] r_valley_min_run;
    logic                           r_out_valid;
    logic [COUNT_WIDTH-1:0]         r_peak_count;
    logic [COUNT_WIDTH-1:0]         r_valley_count;

    pvrc_pkg::t_beat_ctl            w_in_ctl;
    pvrc_pkg::t_beat_ctl            w_step;
    logic signed [SAMPLE_WIDTH-1:0] w_sample;
    logic                           w_advance;
    logic                           w_emit;
    logic                           w_cfg_write;
    logic [COUNT_WIDTH-1:0]         w_peak_count;
    logic [COUNT_WIDTH-1:0]         w_valley_count;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_min_run   <= pvrc_pkg::PEAK_MIN_RUN_RESET;
            r_valley_min_run <= pvrc_pkg::VALLEY_MIN_RUN_RESET;
        end else if (w_cfg_write) begin
            unique case (paddr[2])
                pvrc_pkg::REG_PEAK_MIN_RUN: begin
                    r_peak_min_run <= pwdata[pvrc_pkg::CFG_WIDTH-1:0];
                end
                pvrc_pkg::REG_VALLEY_MIN_RUN: begin
                    r_valley_min_run <= pwdata[pvrc_pkg::CFG_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            pvrc_pkg::REG_PEAK_MIN_RUN: begin
                prdata = pvrc_pkg::PDATA_WIDTH'(r_peak_min_run);
            end
            pvrc_pkg::REG_VALLEY_MIN_RUN: begin
                prdata = pvrc_pkg::PDATA_WIDTH'(r_valley_min_run);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign w_advance   = w_in_ctl.valid && (!w_in_ctl.last || !r_out_valid || !i_out_stall);
    assign w_step.valid = w_advance;
    assign w_step.last  = w_in_ctl.last;
    assign w_emit       = w_advance && w_in_ctl.last;

    pvrc_in_stage #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_last_sample(i_last_sample),
        .i_advance    (w_advance),
        .o_ctl        (w_in_ctl),
        .o_sample     (w_sample)
    );

    pvrc_tracker #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .RUN_WIDTH   (RUN_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tracker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_sample        (w_sample),
        .i_peak_min_run  (r_peak_min_run),
        .i_valley_min_run(r_valley_min_run),
        .o_peak_count    (w_peak_count),
        .o_valley_count  (w_valley_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_peak_count   <= w_peak_count;
            r_valley_count <= w_valley_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_peak_count   = r_peak_count;
    assign o_valley_count = r_valley_count;

`ifndef SYNTHESIS
    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> o_out_valid)
        else $error("Result beat was not presented after a last sample.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_emit && r_out_valid && i_out_stall))
        else $error("Stalled result was overwritten.");

    a_stall_needs_held_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (w_in_ctl.valid && w_in_ctl.last && r_out_valid && i_out_stall))
        else $error("Input stalled without a blocked last beat.");
`endif

endmodule

`default_nettype wire
